// ----- hdl/wrts_pkg.sv -----
// ----------------------------------------------------------------------------
// wrts_pkg
// Shared types and constants for the weighted random target selector.
// ----------------------------------------------------------------------------
package wrts_pkg;

    // Table geometry
    localparam int MAX_TARGETS = 16;
    localparam int WEIGHT_BITS = 24;
    localparam int IDX_W       = $clog2(MAX_TARGETS);
    localparam int CNT_W       = $clog2(MAX_TARGETS + 1);
    localparam int PW_W        = WEIGHT_BITS + IDX_W;

    // Fixed field widths
    localparam int ID_W     = 32;
    localparam int SLOT_W   = 4;
    localparam int DRAW_W   = 64;
    localparam int WFIELD_W = 24;
    localparam int BIT_CNT_W = $clog2(DRAW_W);

    // Request modes
    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_APPEND = 2'd1,
        MODE_SETCON = 2'd2,
        MODE_SELECT = 2'd3
    } t_mode;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_TARGET  = 3'd1,
        ST_ZERO_TOTAL = 3'd2,
        ST_FULL       = 3'd3,
        ST_BAD_SLOT   = 3'd4
    } t_status;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SCAN,
        S_ID
    } t_state;

    typedef struct packed {
        t_mode               mode;
        logic [ID_W-1:0]     entry_id;
        logic [WFIELD_W-1:0] entry_weight;
        logic                entry_valid;
        logic [SLOT_W-1:0]   slot_index;
        logic                connected;
        logic [DRAW_W-1:0]   draw;
    } t_req;

    typedef struct packed {
        t_status           status;
        logic              found;
        logic [SLOT_W-1:0] chosen_slot;
        logic [ID_W-1:0]   chosen_id;
    } t_rsp;

endpackage

// ----- hdl/weighted_random_target_selector_top.sv -----
// ----------------------------------------------------------------------------
// weighted_random_target_selector_top
// Weighted target table with modulo-draw selection and connected-slot scan.
// ----------------------------------------------------------------------------
// Clear, append and set-connected requests finish at once, and so does a
// select on an empty table or a zero total weight. Busy stays low and the
// result strobe o_done is high in the cycle after the request. Any other
// select holds busy high through the modulo, the prefix search up to the
// slot where it stops, and the connected scan, which visits slots up to
// and including the hit. When no slot is connected, the scan visits every
// slot. The select result strobes in the first cycle with busy low. The
// next request can be taken at the edge that ends that cycle.
// One 29-bit subtract/compare unit does the 64-step restoring modulo of
// the draw by the total weight, then the prefix search, one slot at a
// time through the registered table read. Each result is shown with
// o_done high for exactly one cycle and stays on o_rsp until the next
// request; the receiver must take it.
// ----------------------------------------------------------------------------
module weighted_random_target_selector_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  wrts_pkg::t_req i_req,
    output logic           o_busy,
    output logic           o_done,
    output wrts_pkg::t_rsp o_rsp
);
    import wrts_pkg::*;

    localparam int CMP_W = PW_W + 2;
    localparam int SC_W  = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

    // Sequencer and table control
    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [PW_W-1:0]       r_total, n_total;
    logic [MAX_TARGETS-1:0] r_conn, n_conn;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [CNT_W-1:0]      r_scan, n_scan;
    logic [BIT_CNT_W-1:0]  r_bit, n_bit;
    logic [DRAW_W-1:0]     r_dvd, n_dvd;
    logic [PW_W-1:0]       r_rem, n_rem;
    logic                  r_done, n_done;
    t_rsp                  r_rsp, n_rsp;

    // Table memories
    logic [PW_W-1:0] prefix_mem [MAX_TARGETS];
    logic [ID_W-1:0] id_mem     [MAX_TARGETS];
    logic [PW_W-1:0] r_pw_rd;
    logic [ID_W-1:0] r_id_rd;
    logic            w_we;
    logic [IDX_W-1:0] w_waddr;
    logic [PW_W-1:0] w_sum;

    // Shared subtract/compare unit
    logic [PW_W:0]    w_cmp_a, w_cmp_b;
    logic [CMP_W-1:0] w_diff;
    logic             w_ge;

    logic             w_last;
    logic [IDX_W-1:0] w_slot;
    logic             w_bad_slot;

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    assign w_waddr    = r_count[IDX_W-1:0];
    assign w_sum      = r_total + PW_W'(i_req.entry_weight[WEIGHT_BITS-1:0]);
    assign w_last     = (CNT_W'(r_idx) == r_count - CNT_W'(1));
    assign w_slot     = IDX_W'(i_req.slot_index);
    assign w_bad_slot = (SC_W'(i_req.slot_index) >= SC_W'(r_count));

    // Select operands: modulo step in S_DIV, prefix compare otherwise
    always_comb begin
        if (r_state == S_DIV) begin
            w_cmp_a = {r_rem, r_dvd[DRAW_W-1]};
            w_cmp_b = {1'b0, r_total};
        end else begin
            w_cmp_a = {1'b0, r_rem};
            w_cmp_b = {1'b0, r_pw_rd};
        end
        w_diff = {1'b0, w_cmp_a} - {1'b0, w_cmp_b};
        w_ge   = ~w_diff[CMP_W-1];
    end

    // Write appended entries, read at the sequencer index
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            prefix_mem[w_waddr] <= w_sum;
            id_mem[w_waddr]     <= i_req.entry_id;
        end
        r_pw_rd <= prefix_mem[r_idx];
        r_id_rd <= id_mem[r_idx];
    end

    // Next state and outputs
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_total = r_total;
        n_conn  = r_conn;
        n_idx   = r_idx;
        n_scan  = r_scan;
        n_bit   = r_bit;
        n_dvd   = r_dvd;
        n_rem   = r_rem;
        n_done  = 1'b0;
        n_rsp   = r_rsp;
        w_we    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_rsp = '{status: ST_OK, found: 1'b0, chosen_slot: '0, chosen_id: '0};
                    unique case (i_req.mode)
                        MODE_CLEAR: begin
                            n_count = '0;
                            n_total = '0;
                            n_conn  = '0;
                            n_done  = 1'b1;
                        end
                        MODE_APPEND: begin
                            n_done = 1'b1;
                            if (i_req.entry_valid) begin
                                if (r_count == CNT_W'(MAX_TARGETS)) begin
                                    n_rsp.status = ST_FULL;
                                end else begin
                                    w_we            = 1'b1;
                                    n_total         = w_sum;
                                    n_conn[w_waddr] = 1'b1;
                                    n_count         = r_count + CNT_W'(1);
                                end
                            end
                        end
                        MODE_SETCON: begin
                            n_done = 1'b1;
                            if (w_bad_slot) begin
                                n_rsp.status = ST_BAD_SLOT;
                            end else begin
                                n_conn[w_slot] = i_req.connected;
                            end
                        end
                        MODE_SELECT: begin
                            if (r_count == '0) begin
                                n_done       = 1'b1;
                                n_rsp.status = ST_NO_TARGET;
                            end else if (r_total == '0) begin
                                n_done       = 1'b1;
                                n_rsp.status = ST_ZERO_TOTAL;
                            end else begin
                                n_dvd   = i_req.draw;
                                n_rem   = '0;
                                n_bit   = '0;
                                n_state = S_DIV;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            // Restoring modulo, one draw bit per cycle
            S_DIV: begin
                n_rem = w_ge ? w_diff[PW_W-1:0] : w_cmp_a[PW_W-1:0];
                n_dvd = r_dvd << 1;
                n_bit = r_bit + BIT_CNT_W'(1);
                if (r_bit == BIT_CNT_W'(DRAW_W - 1)) begin
                    n_idx   = '0;
                    n_state = S_SRCH_RD;
                end
            end
            // Wait for the registered prefix read
            S_SRCH_RD: begin
                n_state = S_SRCH_CMP;
            end
            // Stop at the first prefix above the remainder, or the last slot
            S_SRCH_CMP: begin
                if (!w_ge || w_last) begin
                    n_scan  = '0;
                    n_state = S_SCAN;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = S_SRCH_RD;
                end
            end
            // Advance with wrap to the first connected slot, or report no target after every slot
            S_SCAN: begin
                if (r_conn[r_idx]) begin
                    n_state = S_ID;
                end else if (r_scan == r_count - CNT_W'(1)) begin
                    n_done       = 1'b1;
                    n_rsp.status = ST_NO_TARGET;
                    n_state      = S_IDLE;
                end else begin
                    n_scan = r_scan + CNT_W'(1);
                    n_idx  = w_last ? '0 : r_idx + IDX_W'(1);
                end
            end
            // Id read is back: report the hit
            S_ID: begin
                n_done            = 1'b1;
                n_rsp.status      = ST_OK;
                n_rsp.found       = 1'b1;
                n_rsp.chosen_slot = SLOT_W'(r_idx);
                n_rsp.chosen_id   = r_id_rd;
                n_state           = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_total <= '0;
            r_conn  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_total <= n_total;
            r_conn  <= n_conn;
            r_done  <= n_done;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_scan <= n_scan;
        r_bit  <= n_bit;
        r_dvd  <= n_dvd;
        r_rem  <= n_rem;
        r_rsp  <= n_rsp;
    end

    // Checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_TARGETS))
        else $error("entry count above table size");

    a_rem_below_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH_RD) |-> (r_rem < r_total))
        else $error("modulo remainder not below total weight");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.found) |-> (o_rsp.status == ST_OK))
        else $error("found result with error status");

    a_found_connected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.found) |->
            (r_conn[IDX_W'(o_rsp.chosen_slot)] &&
             (SC_W'(o_rsp.chosen_slot) < SC_W'(r_count))))
        else $error("chosen slot not a connected table entry");

    a_done_after_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ID) |=> (o_done && o_rsp.found && !o_busy))
        else $error("id stage did not deliver a hit");

endmodule
